FILE: hdl/gjmi_pkg.sv
`default_nettype none
package gjmi_pkg;
    localparam int DIM_DEF       = 4;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int THR_W         = 16;

    typedef enum logic [10:0] {
        ST_LOAD   = 11'b00000000001,
        ST_INIT   = 11'b00000000010,
        ST_SEARCH = 11'b00000000100,
        ST_SWAP   = 11'b00000001000,
        ST_PIVRD  = 11'b00000010000,
        ST_NORM   = 11'b00000100000,
        ST_FACT   = 11'b00001000000,
        ST_ELIM   = 11'b00010000000,
        ST_NEXT   = 11'b00100000000,
        ST_EMIT   = 11'b01000000000,
        ST_SING   = 11'b10000000000
    } gjmi_state_t;

    typedef enum logic [3:0] {
        CMD_NONE    = 4'd0,
        CMD_LOAD    = 4'd1,
        CMD_INIT    = 4'd2,
        CMD_SWAP    = 4'd3,
        CMD_PIVRD   = 4'd4,
        CMD_DIV     = 4'd5,
        CMD_FACT    = 4'd6,
        CMD_MAC     = 4'd7,
        CMD_EMIT    = 4'd8
    } gjmi_op_t;

    typedef struct packed {
        gjmi_op_t   op;
        logic [7:0] row;
        logic [7:0] row2;
        logic [7:0] col;
        logic       inv_side;
    } gjmi_cmd_t;

    typedef struct packed {
        logic busy;
        logic nonzero;
    } gjmi_stat_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [95:0] v);
        logic signed [95:0] hi;
        logic signed [95:0] lo;
        begin
            hi = 96'sh7FFFFFFF;
            lo = -96'sh80000000;
            if (v > hi) sat32 = 32'sh7FFFFFFF;
            else if (v < lo) sat32 = 32'sh80000000;
            else sat32 = v[DATA_W-1:0];
        end
    endfunction
endpackage
`default_nettype wire

FILE: hdl/gjmi_div.sv
`default_nettype none
module gjmi_div
    import gjmi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [DATA_W-1:0] num,
    input  wire logic signed [DATA_W-1:0] den,
    output logic                          done,
    output logic signed [DATA_W-1:0]      quo
);
    localparam int NW = DATA_W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]     n_reg;
    logic [NW:0]       r_reg;
    logic [DATA_W-1:0] d_reg;
    logic [NW-1:0]     q_reg;
    logic [CW-1:0]     cnt_reg;
    logic              neg_reg;
    logic              run_reg;
    logic [NW:0]       rs;
    logic [NW:0]       rsub;
    logic signed [95:0] qs;

    assign rs   = {r_reg[NW-1:0], n_reg[NW-1]};
    assign rsub = rs - {{(NW+1-DATA_W){1'b0}}, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done    <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= {(num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num)), {FRAC_BITS{1'b0}}};
            d_reg   <= den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
            neg_reg <= num[DATA_W-1] ^ den[DATA_W-1];
            r_reg   <= '0;
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            n_reg <= {n_reg[NW-2:0], 1'b0};
            if (!rsub[NW])
            begin
                r_reg <= rsub;
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= rs;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        qs  = 96'(q_reg);
        quo = sat32(neg_reg ? -qs : qs);
    end
endmodule
`default_nettype wire

FILE: hdl/gjmi_datapath.sv
`default_nettype none
module gjmi_datapath
    import gjmi_pkg::*;
#(
    parameter int DIM       = DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire gjmi_pkg::gjmi_cmd_t      cmd,
    input  wire logic [gjmi_pkg::THR_W-1:0] zero_threshold,
    input  wire logic signed [gjmi_pkg::DATA_W-1:0] element_value,
    output gjmi_pkg::gjmi_stat_t          stat,
    output logic signed [gjmi_pkg::DATA_W-1:0] elem_out
);
    localparam int CELLS = DIM * DIM;
    localparam int IW    = $clog2(DIM);

    logic signed [DATA_W-1:0] wm_reg [CELLS];
    logic signed [DATA_W-1:0] im_reg [CELLS];
    logic signed [DATA_W-1:0] piv_reg;
    logic signed [DATA_W-1:0] fac_reg;
    logic signed [DATA_W-1:0] prod_reg;
    logic                     mac_ph_reg;
    logic                     div_start;
    logic                     div_done;
    logic                     div_busy_reg;
    logic signed [DATA_W-1:0] div_q;
    logic [IW-1:0]            r;
    logic [IW-1:0]            r2;
    logic [IW-1:0]            c;
    logic signed [DATA_W-1:0] cur;
    logic signed [DATA_W-1:0] prow;
    logic signed [DATA_W-1:0] colv;
    logic signed [DATA_W:0]   mag;
    logic signed [63:0]       p64;
    logic signed [95:0]       pw;
    logic signed [95:0]       pq;
    logic signed [95:0]       sum;

    assign r  = cmd.row[IW-1:0];
    assign r2 = cmd.row2[IW-1:0];
    assign c  = cmd.col[IW-1:0];

    assign cur  = cmd.inv_side ? im_reg[r*DIM+c] : wm_reg[r*DIM+c];
    assign prow = cmd.inv_side ? im_reg[r2*DIM+c] : wm_reg[r2*DIM+c];
    assign colv = wm_reg[r*DIM+c];
    assign mag  = colv[DATA_W-1] ? -(DATA_W+1)'(colv) : (DATA_W+1)'(colv);

    assign stat = '{
        busy:    (div_busy_reg && !div_done) || div_start ||
                 (cmd.op == CMD_MAC && !mac_ph_reg),
        nonzero: mag > (DATA_W+1)'(zero_threshold)
    };
    assign div_start    = cmd.op == CMD_DIV && !div_busy_reg;
    assign elem_out     = im_reg[r*DIM+c];

    always_comb
    begin
        p64 = 64'(fac_reg) * 64'(prow);
        pw  = 96'(p64);
        pq  = (pw + (pw[95] ? ((96'sd1 <<< FRAC_BITS) - 96'sd1) : 96'sd0)) >>> FRAC_BITS;
        sum = 96'(prod_reg) + 96'(cur);
    end

    gjmi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (cur),
        .den  (piv_reg),
        .done (div_done),
        .quo  (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            mac_ph_reg   <= 1'b0;
        end
        else
        begin
            if (div_start) div_busy_reg <= 1'b1;
            else if (div_done) div_busy_reg <= 1'b0;
            if (cmd.op == CMD_MAC) mac_ph_reg <= !mac_ph_reg;
            else mac_ph_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            CMD_LOAD:  wm_reg[r*DIM+c] <= element_value;
            CMD_INIT:
            begin
                for (int i = 0; i < DIM; i++)
                    for (int j = 0; j < DIM; j++)
                        im_reg[i*DIM+j] <= (i == j) ?
                            DATA_W'(64'sd1 <<< FRAC_BITS) : '0;
            end
            CMD_SWAP:
            begin
                for (int j = 0; j < DIM; j++)
                begin
                    wm_reg[r*DIM+j]  <= wm_reg[r2*DIM+j];
                    wm_reg[r2*DIM+j] <= wm_reg[r*DIM+j];
                    im_reg[r*DIM+j]  <= im_reg[r2*DIM+j];
                    im_reg[r2*DIM+j] <= im_reg[r*DIM+j];
                end
            end
            CMD_PIVRD: piv_reg <= colv;
            CMD_DIV:
            begin
                if (div_done)
                begin
                    if (cmd.inv_side) im_reg[r*DIM+c] <= div_q;
                    else wm_reg[r*DIM+c] <= div_q;
                end
            end
            CMD_FACT:  fac_reg <= (colv == 32'sh80000000) ? 32'sh7FFFFFFF : -colv;
            CMD_MAC:
            begin
                if (!mac_ph_reg) prod_reg <= sat32(pq);
                else if (cmd.inv_side) im_reg[r*DIM+c] <= sat32(sum);
                else wm_reg[r*DIM+c] <= sat32(sum);
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

FILE: hdl/gjmi_ctrl.sv
`default_nettype none
module gjmi_ctrl
    import gjmi_pkg::*;
#(
    parameter int DIM = DIM_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      singular,
    output logic                      last,
    input  wire gjmi_pkg::gjmi_stat_t stat,
    output gjmi_pkg::gjmi_cmd_t       cmd
);
    localparam int IW = $clog2(DIM);

    gjmi_state_t st_reg, st_next;
    logic [IW-1:0] row_reg, row_next, col_reg, col_next, c_reg, c_next, pc_reg, pc_next;
    logic          inv_reg, inv_next;
    logic          eov;

    assign eov = (c_reg == IW'(DIM - 1));
    assign in_ready  = st_reg == ST_LOAD;
    assign out_valid = st_reg == ST_EMIT || st_reg == ST_SING;
    assign singular  = st_reg == ST_SING;
    assign last      = singular || (row_reg == IW'(DIM - 1) && eov);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_LOAD;
            row_reg <= '0;
            col_reg <= '0;
            c_reg   <= '0;
            pc_reg  <= '0;
            inv_reg <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            row_reg <= row_next;
            col_reg <= col_next;
            c_reg   <= c_next;
            pc_reg  <= pc_next;
            inv_reg <= inv_next;
        end
    end

    always_comb
    begin
        st_next  = st_reg;
        row_next = row_reg;
        col_next = col_reg;
        c_next   = c_reg;
        pc_next  = pc_reg;
        inv_next = inv_reg;
        cmd.op   = CMD_NONE;
        cmd.row  = 8'(row_reg);
        cmd.row2 = 8'(pc_reg);
        cmd.col  = 8'(c_reg);
        cmd.inv_side = inv_reg;
        case (st_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.op = CMD_LOAD;
                    c_next = c_reg + 1'b1;
                    if (eov)
                    begin
                        c_next   = '0;
                        row_next = row_reg + 1'b1;
                        if (row_reg == IW'(DIM - 1))
                        begin
                            row_next = '0;
                            st_next  = ST_INIT;
                        end
                    end
                end
            end
            ST_INIT:
            begin
                cmd.op   = CMD_INIT;
                col_next = '0;
                row_next = '0;
                st_next  = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                cmd.col = 8'(col_reg);
                if (stat.nonzero)
                begin
                    pc_next = row_reg;
                    st_next = ST_SWAP;
                end
                else if (row_reg == IW'(DIM - 1)) st_next = ST_SING;
                else row_next = row_reg + 1'b1;
            end
            ST_SWAP:
            begin
                cmd.op   = CMD_SWAP;
                cmd.row  = 8'(col_reg);
                cmd.row2 = 8'(pc_reg);
                st_next  = ST_PIVRD;
            end
            ST_PIVRD:
            begin
                cmd.op   = CMD_PIVRD;
                cmd.row  = 8'(col_reg);
                cmd.col  = 8'(col_reg);
                c_next   = col_reg;
                inv_next = 1'b0;
                st_next  = ST_NORM;
            end
            ST_NORM:
            begin
                cmd.op  = CMD_DIV;
                cmd.row = 8'(col_reg);
                if (!stat.busy)
                begin
                    c_next = c_reg + 1'b1;
                    if (eov)
                    begin
                        c_next = '0;
                        if (inv_reg)
                        begin
                            inv_next = 1'b0;
                            row_next = (col_reg == '0) ? IW'(1) : '0;
                            st_next  = ST_FACT;
                        end
                        else inv_next = 1'b1;
                    end
                end
            end
            ST_FACT:
            begin
                cmd.op   = CMD_FACT;
                cmd.col  = 8'(col_reg);
                c_next   = col_reg;
                inv_next = 1'b0;
                st_next  = ST_ELIM;
            end
            ST_ELIM:
            begin
                cmd.op   = CMD_MAC;
                cmd.row2 = 8'(col_reg);
                if (!stat.busy)
                begin
                    c_next = c_reg + 1'b1;
                    if (eov)
                    begin
                        c_next = '0;
                        if (inv_reg) st_next = ST_NEXT;
                        else inv_next = 1'b1;
                    end
                end
            end
            ST_NEXT:
            begin
                if (row_reg == IW'(DIM - 1) ||
                    (row_reg == IW'(DIM - 2) && col_reg == IW'(DIM - 1)))
                begin
                    if (col_reg == IW'(DIM - 1))
                    begin
                        row_next = '0;
                        c_next   = '0;
                        st_next  = ST_EMIT;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                        row_next = col_reg + 1'b1;
                        st_next  = ST_SEARCH;
                    end
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    if (row_next == col_reg) row_next = row_reg + IW'(2);
                    st_next = ST_FACT;
                end
            end
            ST_EMIT:
            begin
                cmd.op = CMD_EMIT;
                if (out_ready)
                begin
                    c_next = c_reg + 1'b1;
                    if (eov)
                    begin
                        c_next   = '0;
                        row_next = row_reg + 1'b1;
                        if (row_reg == IW'(DIM - 1))
                        begin
                            row_next = '0;
                            st_next  = ST_LOAD;
                        end
                    end
                end
            end
            ST_SING:
            begin
                if (out_ready)
                begin
                    row_next = '0;
                    c_next   = '0;
                    st_next  = ST_LOAD;
                end
            end
            default: st_next = ST_LOAD;
        endcase
    end
endmodule
`default_nettype wire

FILE: hdl/gauss_jordan_matrix_inverse_core.sv
// Fixed-point DIM x DIM matrix inverter (Gauss-Jordan with row pivoting).
// Input channel in_valid/in_ready: element_value, row-major, signed Q16.16.
// Output channel out_valid/out_ready: element_value_out, singular, last.
// Config channel cfg_valid/cfg_ready: cfg_data writes zero_threshold;
// always ready, write only while idle.
// After the last of DIM*DIM elements the block runs elimination: each
// division runs in the bit-serial divider, and each multiply-add first
// registers the saturated product, then writes the saturated sum. A
// singular matrix ends elimination sooner than a regular matrix does.
// It then emits DIM*DIM elements, last on the final one, or a single request
// with singular=1 and a zero element. Input is not taken during inversion
// or output. A stalled receiver holds the block in the output phase.
// Reset clears the threshold to 0 and restarts loading at element 0.
`default_nettype none
module gauss_jordan_matrix_inverse_core
#(
    parameter int DIM       = gjmi_pkg::DIM_DEF,
    parameter int FRAC_BITS = gjmi_pkg::FRAC_BITS_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [gjmi_pkg::DATA_W-1:0] element_value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [gjmi_pkg::DATA_W-1:0]     element_value_out,
    output logic                                   singular,
    output logic                                   last,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [gjmi_pkg::THR_W-1:0]        cfg_data
);
    import gjmi_pkg::*;

    gjmi_cmd_t          cmd;
    gjmi_stat_t         stat;
    logic [THR_W-1:0]   thr_reg;
    logic signed [DATA_W-1:0] eo;

    assign cfg_ready = 1'b1;
    assign element_value_out = singular ? '0 : eo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) thr_reg <= '0;
        else if (cfg_valid) thr_reg <= cfg_data;
    end

    gjmi_ctrl #(.DIM(DIM)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .singular (singular),
        .last     (last),
        .stat     (stat),
        .cmd      (cmd)
    );

    gjmi_datapath #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .zero_threshold(thr_reg),
        .element_value (element_value),
        .stat          (stat),
        .elem_out      (eo)
    );
endmodule
`default_nettype wire

FILE: hdl/gjmi_checker.sv
`default_nettype none
module gjmi_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic singular,
    input wire logic last,
    input wire logic [31:0] element_value_out
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input and output active together");
    a_sing_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> last && element_value_out == 32'd0)
        else $error("singular request malformed");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(element_value_out))
        else $error("stalled output changed");
    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> !out_valid)
        else $error("output continued after last");
endmodule

bind gauss_jordan_matrix_inverse_core gjmi_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .singular(singular),
    .last(last), .element_value_out(element_value_out)
);
`default_nettype wire

FILE: bench/gauss_jordan_matrix_inverse_core_tb.sv
`timescale 1ns / 100ps
module gauss_jordan_matrix_inverse_core_tb;
    import gjmi_pkg::*;

    localparam int N     = DIM_DEF;
    localparam int CELLS = N * N;
    localparam int FB    = FRAC_BITS_DEF;
    localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
    localparam logic signed [31:0] MINV = 32'sh80000000;

    typedef enum int {MX_WELL, MX_FULL, MX_SING, MX_TINY} mx_kind_t;

    typedef struct {
        logic signed [31:0] value;
        logic               sing;
        logic               lst;
    } inv_elem_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [31:0] element_value;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] element_value_out;
    logic singular;
    logic last;
    logic cfg_valid;
    logic cfg_ready;
    logic [THR_W-1:0] cfg_data;

    logic signed [31:0] pending_elems[$];
    inv_elem_t          expected_inv[$];
    logic signed [31:0] mat_a[CELLS];
    logic signed [31:0] mat_b[CELLS];
    int unsigned        loaded;
    logic [15:0]        threshold;
    int                 errors;
    int                 in_gap;
    int                 out_stall;
    bit                 quiet;

    gauss_jordan_matrix_inverse_core u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .element_value     (element_value),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .element_value_out (element_value_out),
        .singular          (singular),
        .last              (last),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    function automatic logic signed [31:0] clip(longint v);
        if (v > longint'(MAXV))
        begin
            return MAXV;
        end
        if (v < longint'(MINV))
        begin
            return MINV;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] q_div(logic signed [31:0] a, logic signed [31:0] d);
        longint n;
        n = longint'(a) * (longint'(1) <<< FB);
        return clip(n / longint'(d));
    endfunction

    function automatic logic signed [31:0] q_muladd(logic signed [31:0] f,
                                                     logic signed [31:0] x,
                                                     logic signed [31:0] acc);
        longint p;
        p = (longint'(f) * longint'(x)) / (longint'(1) <<< FB);
        return clip(longint'(clip(p)) + longint'(acc));
    endfunction

    // run elimination on mat_a into mat_b; returns 0 when no pivot is found
    function automatic bit gauss_jordan();
        int piv;
        longint mag;
        logic signed [31:0] t;
        logic signed [31:0] b;
        logic signed [31:0] f;
        for (int i = 0; i < CELLS; i++)
        begin
            mat_b[i] = (i % (N + 1) == 0) ? (32'sd1 <<< FB) : 32'sd0;
        end
        for (int col = 0; col < N; col++)
        begin
            piv = col;
            while (piv < N)
            begin
                mag = longint'(mat_a[piv * N + col]);
                if (mag < 0)
                begin
                    mag = -mag;
                end
                if (mag > longint'(threshold))
                begin
                    break;
                end
                piv++;
            end
            if (piv >= N)
            begin
                return 0;
            end
            if (piv != col)
            begin
                for (int c = 0; c < N; c++)
                begin
                    t = mat_a[piv * N + c];
                    mat_a[piv * N + c] = mat_a[col * N + c];
                    mat_a[col * N + c] = t;
                    t = mat_b[piv * N + c];
                    mat_b[piv * N + c] = mat_b[col * N + c];
                    mat_b[col * N + c] = t;
                end
            end
            b = mat_a[col * N + col];
            for (int c = col; c < N; c++)
            begin
                mat_a[col * N + c] = q_div(mat_a[col * N + c], b);
            end
            for (int c = 0; c < N; c++)
            begin
                mat_b[col * N + c] = q_div(mat_b[col * N + c], b);
            end
            for (int r = 0; r < N; r++)
            begin
                if (r != col)
                begin
                    f = (mat_a[r * N + col] == MINV) ? MAXV : -mat_a[r * N + col];
                    for (int c = col; c < N; c++)
                    begin
                        mat_a[r * N + c] = q_muladd(f, mat_a[col * N + c], mat_a[r * N + c]);
                    end
                    for (int c = 0; c < N; c++)
                    begin
                        mat_b[r * N + c] = q_muladd(f, mat_b[col * N + c], mat_b[r * N + c]);
                    end
                end
            end
        end
        return 1;
    endfunction

    task automatic load_element(logic signed [31:0] v);
        inv_elem_t e;
        mat_a[loaded] = v;
        loaded++;
        if (loaded == CELLS)
        begin
            loaded = 0;
            if (!gauss_jordan())
            begin
                e.value = 0;
                e.sing  = 1;
                e.lst   = 1;
                expected_inv.push_back(e);
            end
            else
            begin
                for (int k = 0; k < CELLS; k++)
                begin
                    e.value = mat_b[k];
                    e.sing  = 0;
                    e.lst   = (k == CELLS - 1);
                    expected_inv.push_back(e);
                end
            end
        end
    endtask

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic signed [31:0] rnd32();
        return $urandom();
    endfunction

    task automatic add_matrix(mx_kind_t kind);
        logic signed [31:0] m[CELLS];
        logic signed [31:0] t;
        int r1;
        int r2;
        for (int i = 0; i < CELLS; i++)
        begin
            case (kind)
                MX_WELL:
                begin
                    if (i % (N + 1) == 0)
                    begin
                        m[i] = $urandom_range(32'h10000, 32'h40000);
                        if ($urandom_range(0, 1))
                        begin
                            m[i] = -m[i];
                        end
                    end
                    else
                    begin
                        m[i] = $signed($urandom_range(0, 32'hFFFF)) - 32'sh8000;
                    end
                end
                MX_TINY: m[i] = $signed($urandom_range(0, 400)) - 200;
                default: m[i] = rnd32();
            endcase
        end
        if (kind == MX_SING)
        begin
            r1 = $urandom_range(0, N - 1);
            r2 = (r1 + $urandom_range(1, N - 1)) % N;
            for (int c = 0; c < N; c++)
            begin
                if ($urandom_range(0, 1))
                begin
                    m[r2 * N + c] = m[r1 * N + c];
                end
                else
                begin
                    m[c * N + r2] = 0;
                end
            end
        end
        if (kind == MX_WELL && $urandom_range(0, 1))
        begin
            r1 = $urandom_range(0, N - 1);
            r2 = (r1 + $urandom_range(1, N - 1)) % N;
            for (int c = 0; c < N; c++)
            begin
                t = m[r1 * N + c];
                m[r1 * N + c] = m[r2 * N + c];
                m[r2 * N + c] = t;
            end
        end
        for (int i = 0; i < CELLS; i++)
        begin
            pending_elems.push_back(m[i]);
        end
    endtask

    task automatic write_threshold(logic [15:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        threshold = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_elems.size() != 0 || in_valid || expected_inv.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2000) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            element_value <= '0;
            in_gap        = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                load_element(element_value);
            end
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_elems.size() != 0)
            begin
                in_valid      <= 1'b1;
                element_value <= pending_elems.pop_front();
                if (!quiet && $urandom_range(0, 9) == 0)
                begin
                    in_gap = $urandom_range(1, 18);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        inv_elem_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_inv.size() == 0)
                begin
                    report("unexpected result", element_value_out, 0);
                end
                else
                begin
                    e = expected_inv.pop_front();
                    if (element_value_out !== e.value)
                    begin
                        report("element_value_out", element_value_out, e.value);
                    end
                    if (singular !== e.sing)
                    begin
                        report("singular", singular, e.sing);
                    end
                    if (last !== e.lst)
                    begin
                        report("last", last, e.lst);
                    end
                end
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                begin
                    out_stall = $urandom_range(1, 18);
                end
            end
        end
    end

    initial
    begin
        logic [15:0] thr_list[4];
        errors    = 0;
        loaded    = 0;
        threshold = 0;
        quiet     = 0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // extremes, a pivot that needs a row swap, a zero column
        for (int i = 0; i < CELLS; i++)
        begin
            pending_elems.push_back(i % 5 == 0 ? ((i & 1) ? MINV : MAXV) :
                                    (i % 3 == 0 ? 32'sd1 : -32'sd1));
        end
        for (int i = 0; i < CELLS; i++)
        begin
            pending_elems.push_back(i == 0 ? 32'sd0 : ((i % 5 == 4) ? 32'sh10000 : i << 12));
        end
        for (int i = 0; i < CELLS; i++)
        begin
            pending_elems.push_back(i % N == 1 ? 32'sd0 : rnd32());
        end
        drain();

        thr_list[0] = 16'hFFFF;
        thr_list[1] = 16'd100;
        thr_list[2] = 16'($urandom_range(0, 16'hFFFF));
        thr_list[3] = 16'd0;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_threshold(thr_list[ph]);
            quiet = (ph == 3);
            for (int k = 0; k < 6; k++)
            begin
                case ($urandom_range(0, 9))
                    0, 1:    add_matrix(MX_FULL);
                    2:       add_matrix(MX_SING);
                    3:       add_matrix(MX_TINY);
                    default: add_matrix(MX_WELL);
                endcase
            end
            drain();
        end

        if (errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #3_200_000;
        $display("simulation failed");
        $finish;
    end
endmodule
